@@ src/rpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcm_pkg
// Shared types and constants of the random-partition centroid block.
// ----------------------------------------------------------------------------
package rpcm_pkg;

    // fixed field widths
    localparam int KIND_W    = 2;
    localparam int CLUSTER_W = 4;
    localparam int RCOL_W    = 6;
    localparam int NCL_W     = 5;
    localparam int NCOL_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 40;
    localparam int COUNT_W   = 25;
    localparam int STEP_W    = 6;

    // widest values the queued word must carry over the parameter ranges
    localparam int OP_CL_W   = 8;
    localparam int OP_COL_W  = 10;
    localparam int OP_VAL_W  = 32;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 1'd1;

    // saturation limits
    localparam logic [COUNT_W-1:0] COUNT_HI = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_code_t;

    // one classified word between front and back
    typedef struct packed {
        op_code_t                     code;
        logic                         in_range;
        logic                         last;
        logic [OP_CL_W-1:0]           cluster;
        logic [OP_COL_W-1:0]          column;
        logic signed [OP_VAL_W-1:0]   value;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_CLR  = 6'b100000
    } back_state_t;

endpackage

@@ src/rpcm_front.sv @@
// ----------------------------------------------------------------------------
// rpcm_front
// Accepts input words, tracks row framing and classifies words for the back.
// ----------------------------------------------------------------------------
module rpcm_front #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_COLS     = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpcm_pkg::NCOL_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rpcm_pkg::KIND_W-1:0]       kind,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic [rpcm_pkg::CLUSTER_W-1:0]    cluster,
    input  logic [rpcm_pkg::RCOL_W-1:0]       read_column,
    input  rpcm_pkg::q_status_t               q_status,
    input  rpcm_pkg::back_status_t            b_status,
    output logic                              push,
    output rpcm_pkg::op_t                     push_op
);
    import rpcm_pkg::*;

    localparam int POS_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CMP_W = 11;

    logic [NCL_W-1:0]     num_clusters_reg;
    logic [NCOL_W-1:0]    num_cols_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [CLUSTER_W-1:0] row_cluster_reg;
    logic [CLUSTER_W-1:0] row_cluster_next;
    logic [CMP_W-1:0]     ncols;
    logic                 last;
    logic                 row_in_use;
    logic                 accept;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg <= NCL_W'(16);
            num_cols_reg     <= NCOL_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_CLUSTERS: num_clusters_reg <= cfg_data[NCL_W-1:0];
                REG_NUM_COLS:     num_cols_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_stall = q_status.full || b_status.init_busy;
    assign accept   = in_valid && !in_stall;

    // row framing
    always_comb
    begin
        ncols = (num_cols_reg == '0) ? CMP_W'(1) : CMP_W'(num_cols_reg);
        if (ncols > CMP_W'(MAX_COLS))
        begin
            ncols = CMP_W'(MAX_COLS);
        end
        row_cluster_next = (pos_reg == '0) ? cluster : row_cluster_reg;
        last             = (CMP_W'(pos_reg) + CMP_W'(1)) >= ncols;
        pos_next         = last ? '0 : POS_W'(CMP_W'(pos_reg) + CMP_W'(1));
        row_in_use       = (NCL_W'(row_cluster_next) < num_clusters_reg)
                           && (9'(row_cluster_next) < 9'(MAX_CLUSTERS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            row_cluster_reg <= '0;
        end
        else if (accept && kind == KIND_ACC)
        begin
            pos_reg         <= pos_next;
            row_cluster_reg <= row_cluster_next;
        end
    end

    // classify the word
    always_comb
    begin
        push_op          = '0;
        push             = 1'b0;
        push_op.value    = OP_VAL_W'(value);
        push_op.last     = last;
        case (kind)
            KIND_ACC:
            begin
                push_op.code     = OP_ACC;
                push_op.cluster  = OP_CL_W'(row_cluster_next);
                push_op.column   = OP_COL_W'(pos_reg);
                push_op.in_range = 1'b1;
                push             = accept && row_in_use;
            end
            KIND_READ:
            begin
                push_op.code     = OP_READ;
                push_op.cluster  = OP_CL_W'(cluster);
                push_op.column   = OP_COL_W'(read_column);
                push_op.in_range = (9'(cluster) < 9'(MAX_CLUSTERS))
                                   && (CMP_W'(read_column) < CMP_W'(MAX_COLS));
                push             = accept;
            end
            KIND_CLEAR:
            begin
                push_op.code = OP_CLEAR;
                push         = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ src/rpcm_queue.sv @@
// ----------------------------------------------------------------------------
// rpcm_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rpcm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpcm_pkg::op_t        push_op,
    input  logic                 pop,
    output rpcm_pkg::op_t        head,
    output rpcm_pkg::q_status_t  status
);
    import rpcm_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = fill_reg == 2'd2;
    assign status.empty = fill_reg == 2'd0;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ src/rpcm_back.sv @@
// ----------------------------------------------------------------------------
// rpcm_back
// Sum memory, row counts, serial divider and output register.
// ----------------------------------------------------------------------------
module rpcm_back #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_COLS     = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rpcm_pkg::op_t                  head,
    input  rpcm_pkg::q_status_t            q_status,
    output logic                           pop,
    output rpcm_pkg::back_status_t         status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [VALUE_WIDTH-1:0]  mean,
    output logic                           empty_cluster
);
    import rpcm_pkg::*;

    localparam int DEPTH  = MAX_CLUSTERS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [SUM_W-1:0] VAL_HI  = (SUM_W'(1) << (VALUE_WIDTH - 1)) - SUM_W'(1);
    localparam logic [SUM_W-1:0] VAL_MAG = SUM_W'(1) << (VALUE_WIDTH - 1);

    back_state_t               state_reg;
    back_state_t               state_next;
    op_t                       cur_reg;
    logic [ADDR_W-1:0]         sweep_reg;
    logic                      init_busy_reg;
    logic [COUNT_W-1:0]        count_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]   sums_mem [DEPTH];
    logic signed [SUM_W-1:0]   rd_data_reg;
    logic [SUM_W-1:0]          dvd_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [COUNT_W-1:0]        dsr_reg;
    logic                      neg_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      res_empty_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] mean_reg;
    logic                      empty_reg;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [SUM_W-1:0]   wr_data;
    logic [ADDR_W-1:0]         cur_addr;
    logic [COUNT_W-1:0]        cur_count;
    logic signed [SUM_W:0]     acc_sum;
    logic signed [SUM_W-1:0]   acc_sat;
    logic [COUNT_W:0]          rem_shift;
    logic                      rem_ge;
    logic [SUM_W-1:0]          neg_q;
    logic [VALUE_WIDTH-1:0]    res_mean;
    logic                      out_free;

    assign status.init_busy = init_busy_reg;
    assign out_valid        = out_valid_reg;
    assign mean             = mean_reg;
    assign empty_cluster    = empty_reg;
    assign out_free         = !out_valid_reg || !out_stall;

    assign cur_addr  = ADDR_W'(32'(cur_reg.cluster) * MAX_COLS + 32'(cur_reg.column));
    assign cur_count = count_reg[cur_reg.cluster[CL_W-1:0]];

    // saturating accumulate
    always_comb
    begin
        acc_sum = (SUM_W+1)'(rd_data_reg) + (SUM_W+1)'(cur_reg.value);
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1])
        begin
            acc_sat = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[SUM_W-1:0];
        end
    end

    // one restoring divide step
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dsr_reg};

    // sign and saturate the quotient
    always_comb
    begin
        neg_q = SUM_W'(0) - dvd_reg;
        if (res_empty_reg)
        begin
            res_mean = '0;
        end
        else if (!neg_reg)
        begin
            res_mean = (dvd_reg > VAL_HI) ? VAL_HI[VALUE_WIDTH-1:0]
                                          : dvd_reg[VALUE_WIDTH-1:0];
        end
        else
        begin
            res_mean = (dvd_reg > VAL_MAG) ? VAL_MAG[VALUE_WIDTH-1:0]
                                           : neg_q[VALUE_WIDTH-1:0];
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(32'(head.cluster) * MAX_COLS + 32'(head.column));
        wr_en      = 1'b0;
        wr_addr    = cur_addr;
        wr_data    = acc_sat;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop   = 1'b1;
                    rd_en = 1'b1;
                    case (head.code)
                        OP_ACC:   state_next = S_ACC;
                        OP_READ:  state_next = S_LOAD;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_ACC:
            begin
                wr_en      = 1'b1;
                state_next = S_IDLE;
            end
            S_LOAD:
            begin
                if (!cur_reg.in_range || cur_count == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = '0;
                if (sweep_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sum memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sums_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= sums_mem[rd_addr];
        end
    end

    // state, sweep and row counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            sweep_reg     <= '0;
            init_busy_reg <= 1'b1;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && !q_status.empty && head.code == OP_CLEAR)
            begin
                sweep_reg <= '0;
                for (int i = 0; i < MAX_CLUSTERS; i++)
                begin
                    count_reg[i] <= '0;
                end
            end
            if (state_reg == S_CLR)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(DEPTH - 1))
                begin
                    init_busy_reg <= 1'b0;
                end
            end
            if (state_reg == S_ACC && cur_reg.last && cur_count != COUNT_HI)
            begin
                count_reg[cur_reg.cluster[CL_W-1:0]] <= cur_count + COUNT_W'(1);
            end
        end
    end

    // current word and divider
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        case (state_reg)
            S_LOAD:
            begin
                res_empty_reg <= !cur_reg.in_range || cur_count == '0;
                neg_reg       <= rd_data_reg[SUM_W-1];
                dvd_reg       <= rd_data_reg[SUM_W-1] ? SUM_W'(0) - rd_data_reg
                                                      : rd_data_reg;
                rem_reg       <= '0;
                dsr_reg       <= cur_count;
                step_reg      <= STEP_W'(SUM_W - 1);
            end
            S_DIV:
            begin
                rem_reg  <= rem_ge ? COUNT_W'(rem_shift - {1'b0, dsr_reg})
                                   : rem_shift[COUNT_W-1:0];
                dvd_reg  <= {dvd_reg[SUM_W-2:0], rem_ge};
                step_reg <= step_reg - STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            mean_reg  <= res_mean;
            empty_reg <= res_empty_reg;
        end
    end

endmodule

@@ src/random_partition_centroid_mean.sv @@
// In the back end an accumulate word is read from memory, then added and written back.
// Read words pass memory read, setup, 40 one-bit divide steps and output; a read of
// an empty cluster or an entry outside the store skips the divide.
// Clear words zero the MAX_CLUSTERS*MAX_COLS sum entries, one sum entry per cycle.
// A two-entry queue lets the front accept while the back works; result held in an
// output register. After reset a clearing pass over all MAX_CLUSTERS*MAX_COLS sum
// entries runs with in_stall high; config writes are taken at all times.
// ----------------------------------------------------------------------------
// random_partition_centroid_mean
// K-means random-partition initializer: per-cluster column sums and means.
// ----------------------------------------------------------------------------
module random_partition_centroid_mean #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_COLS     = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpcm_pkg::NCOL_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rpcm_pkg::KIND_W-1:0]       kind,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic [rpcm_pkg::CLUSTER_W-1:0]    cluster,
    input  logic [rpcm_pkg::RCOL_W-1:0]       read_column,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [VALUE_WIDTH-1:0]     mean,
    output logic                              empty_cluster
);
    import rpcm_pkg::*;

    logic         push;
    op_t          push_op;
    logic         pop;
    op_t          head;
    q_status_t    q_status;
    back_status_t b_status;

    // front end
    rpcm_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_COLS     (MAX_COLS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .value       (value),
        .cluster     (cluster),
        .read_column (read_column),
        .q_status    (q_status),
        .b_status    (b_status),
        .push        (push),
        .push_op     (push_op)
    );

    // word queue
    rpcm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    // back end
    rpcm_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_COLS     (MAX_COLS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .status        (b_status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean          (mean),
        .empty_cluster (empty_cluster)
    );

endmodule

@@ tb/tb_random_partition_centroid_mean.sv @@
// ----------------------------------------------------------------------------
// tb_random_partition_centroid_mean
// Streams rows, reads, clears and stray kinds into the centroid block under
// several register settings with random idling on both sides. A scoreboard
// keeps its own sums and counts, predicts every mean and checks each result.
// ----------------------------------------------------------------------------
module tb_random_partition_centroid_mean;
    timeunit 1ns;
    timeprecision 1ps;
    import rpcm_pkg::*;

    localparam int N_CL      = 16;
    localparam int N_COL     = 64;
    localparam int VW        = 16;
    localparam int IDLE_WAIT = 3200;
    localparam int LIMIT     = 60000;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // centroid predictor and store of expected means
    class centroid_scoreboard;
        longint      sums[N_CL][N_COL];
        int unsigned counts[N_CL];
        int unsigned col_pos;
        int unsigned row_cl;
        int unsigned ncl;
        int unsigned ncols;
        logic [VW-1:0] exp_mean[$];
        logic          exp_empty[$];
        int errors;
        int checked;

        function new();
            wipe();
            col_pos = 0;
            row_cl  = 0;
            ncl     = 16;
            ncols   = 64;
            errors  = 0;
            checked = 0;
        endfunction

        function void wipe();
            foreach (sums[c, k]) sums[c][k] = 0;
            foreach (counts[c]) counts[c] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [NCOL_W-1:0] d);
            if (idx == REG_NUM_CLUSTERS)
                ncl = d[NCL_W-1:0];
            else
                ncols = d;
        endfunction

        function void note_input(logic [KIND_W-1:0] k, logic signed [VW-1:0] v,
                                 logic [CLUSTER_W-1:0] cl, logic [RCOL_W-1:0] col);
            int unsigned eff;
            bit          last;
            longint      s;
            longint      m;
            if (k == KIND_ACC) begin
                eff = (ncols == 0) ? 1 : (ncols > N_COL ? N_COL : ncols);
                if (col_pos == 0)
                    row_cl = cl;
                last = (col_pos + 1 >= eff);
                if (row_cl < ncl && col_pos < N_COL) begin
                    s = sums[row_cl][col_pos] + longint'(v);
                    if (s > 64'sd549755813887) s = 64'sd549755813887;
                    if (s < -64'sd549755813888) s = -64'sd549755813888;
                    sums[row_cl][col_pos] = s;
                    if (last && counts[row_cl] < COUNT_HI)
                        counts[row_cl]++;
                end
                col_pos = last ? 0 : col_pos + 1;
            end else if (k == KIND_CLEAR) begin
                wipe();
            end else if (k == KIND_READ) begin
                if (counts[cl] == 0) begin
                    exp_mean.push_back('0);
                    exp_empty.push_back(1'b1);
                end else begin
                    m = sums[cl][col] / longint'(counts[cl]);
                    if (m > 32767) m = 32767;
                    if (m < -32768) m = -32768;
                    exp_mean.push_back(m[VW-1:0]);
                    exp_empty.push_back(1'b0);
                end
            end
        endfunction

        function void check_result(logic [VW-1:0] m, logic e);
            logic [VW-1:0] em;
            logic          ee;
            if (exp_mean.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected word mean=%0d empty=%0b",
                             $signed(m), e);
                return;
            end
            em = exp_mean.pop_front();
            ee = exp_empty.pop_front();
            checked++;
            if (m !== em || e !== ee) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: mean exp %0d got %0d, empty exp %0b got %0b",
                             $signed(em), $signed(m), ee, e);
            end
        endfunction

        function int pending();
            return exp_mean.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [NCOL_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [KIND_W-1:0]        kind;
    logic signed [VW-1:0]     value;
    logic [CLUSTER_W-1:0]     cluster;
    logic [RCOL_W-1:0]        read_column;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [VW-1:0]     mean;
    logic                     empty_cluster;

    centroid_scoreboard sb;
    int sent;
    int clears;
    int idle_cycles;
    int stall_left;

    random_partition_centroid_mean #(
        .MAX_CLUSTERS(N_CL),
        .MAX_COLS(N_COL),
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .value(value), .cluster(cluster), .read_column(read_column),
        .out_valid(out_valid), .out_stall(out_stall),
        .mean(mean), .empty_cluster(empty_cluster)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // short gaps mostly, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side: check accepted words, random stall
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(mean, empty_cluster);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else begin
                stall_left <= pick_gap();
                out_stall  <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("random_partition_centroid_mean verification failed");
            $finish;
        end
    end

    // drive one word and wait until it is taken
    task automatic send_word(logic [KIND_W-1:0] k, logic signed [VW-1:0] v,
                             logic [CLUSTER_W-1:0] cl, logic [RCOL_W-1:0] col);
        int gap;
        in_valid    <= 1'b1;
        kind        <= k;
        value       <= v;
        cluster     <= cl;
        read_column <= col;
        do @(posedge clk); while (in_stall);
        sb.note_input(k, v, cl, col);
        sent++;
        if (k == KIND_CLEAR) clears++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and wait for all expected results
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_regs(logic [NCOL_W-1:0] ncl, logic [NCOL_W-1:0] ncols);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUM_CLUSTERS;
        cfg_data  <= ncl;
        @(posedge clk);
        sb.set_reg(REG_NUM_CLUSTERS, ncl);
        cfg_index <= REG_NUM_COLS;
        cfg_data  <= ncols;
        @(posedge clk);
        sb.set_reg(REG_NUM_COLS, ncols);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random part of one phase: rows with random content, reads, rare clears, stray kinds
    task automatic random_phase(int n, int unsigned cols);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(199);
            if (r < 135)
                send_word(KIND_ACC, VW'($urandom()), CLUSTER_W'($urandom_range(15)),
                          RCOL_W'($urandom()));
            else if (r < 185)
                send_word(KIND_READ, VW'($urandom()), CLUSTER_W'($urandom_range(15)),
                          RCOL_W'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                           : $urandom_range(cols - 1)));
            else if (r < 187)
                send_word(KIND_CLEAR, VW'($urandom()), CLUSTER_W'($urandom()),
                          RCOL_W'($urandom()));
            else
                send_word(KIND_NONE, VW'($urandom()), CLUSTER_W'($urandom()),
                          RCOL_W'($urandom()));
            if (i == n / 2 && cols == 3)
                wait_drained();
        end
    endtask

    initial
    begin
        sb          = new();
        sent        = 0;
        clears      = 0;
        idle_cycles = 0;
        stall_left  = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = '0;
        value       = '0;
        cluster     = '0;
        read_column = '0;
        out_stall   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty clusters at reset settings, stray kind, clear
        send_word(KIND_READ, 0, 0, 0);
        send_word(KIND_READ, 0, 15, 63);
        send_word(KIND_NONE, -1, 15, 63);
        send_word(KIND_CLEAR, 0, 0, 0);

        // three-column rows, two clusters in use
        write_regs(2, 3);
        send_word(KIND_ACC, 16'sh7fff, 0, 0);
        send_word(KIND_ACC, -16'sh8000, 9, 0);
        send_word(KIND_ACC, -3, 9, 0);
        send_word(KIND_ACC, 16'sh7fff, 1, 0);
        send_word(KIND_ACC, -16'sh8000, 1, 0);
        send_word(KIND_ACC, 4, 1, 0);
        send_word(KIND_ACC, 1, 0, 0);
        send_word(KIND_ACC, 0, 0, 0);
        send_word(KIND_ACC, 0, 0, 0);
        // dropped row, cluster out of use
        send_word(KIND_ACC, 100, 15, 0);
        send_word(KIND_ACC, 100, 15, 0);
        send_word(KIND_ACC, 100, 15, 0);
        send_word(KIND_READ, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 1);
        send_word(KIND_READ, 0, 0, 2);
        send_word(KIND_READ, 0, 1, 2);
        send_word(KIND_READ, 0, 15, 0);
        send_word(KIND_READ, 0, 0, 63);
        send_word(KIND_CLEAR, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 0);

        // random phases across settings, extremes included
        write_regs(2, 3);
        random_phase(80, 3);
        write_regs(16, 1);
        random_phase(80, 1);
        write_regs(5, 2);
        random_phase(60, 2);
        write_regs(0, 0);
        random_phase(30, 1);
        write_regs(31, 127);
        random_phase(100, 64);
        write_regs(1, 5);
        random_phase(80, 5);

        wait_drained();
        repeat (200) @(posedge clk);
        $display("covered %0d input words (%0d clears) and %0d checked means",
                 sent, clears, sb.checked);
        $display("settings swept from one column to full rows, zero to all clusters");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("random_partition_centroid_mean verification clean");
        else
            $display("random_partition_centroid_mean verification failed");
        $finish;
    end

endmodule
